@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/alle_pkg.sv @@
// ---------------------------------------------------------------------------
// alle_pkg
// Types and codes shared by the array linked list engine.
// ---------------------------------------------------------------------------
package alle_pkg;

    // Beat field widths
    localparam int CMD_W   = 4;
    localparam int FIELD_W = 32;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 4'd8;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ALLOC,
        S_WALK,
        S_GONE,
        S_LINK2,
        S_FIN
    } t_state;

    // Node store strobes
    typedef struct packed {
        logic rd_en;
        logic lnk_we;
        logic val_we;
    } t_st_ctl;

endpackage

@@ rtl/alle_if.sv @@
// ---------------------------------------------------------------------------
// alle_if
// Command and result channels of the linked list engine (valid/ready).
// ---------------------------------------------------------------------------
interface alle_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [alle_pkg::CMD_W-1:0]          command;
    logic signed [alle_pkg::FIELD_W-1:0] key;
    logic signed [alle_pkg::FIELD_W-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface alle_res_if;
    logic                                valid;
    logic                                ready;
    logic [alle_pkg::STAT_W-1:0]         status;
    logic signed [alle_pkg::FIELD_W-1:0] item_value;
    logic [alle_pkg::SLOT_W-1:0]         slot;
    logic                                last;

    modport source (output valid, status, item_value, slot, last, input ready);
    modport sink   (input valid, status, item_value, slot, last, output ready);
endinterface

@@ rtl/alle_store.sv @@
// ---------------------------------------------------------------------------
// alle_store
// Node store: value and link memories, one write port each, one shared
// registered read port. Link entries read as "next slot" until written.
// ---------------------------------------------------------------------------
module alle_store #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  alle_pkg::t_st_ctl            i_ctl,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     i_lnk_waddr,
    input  logic [$clog2(DEPTH+1)-1:0]   i_lnk_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_val_waddr,
    input  logic [DATA_WIDTH-1:0]        i_val_wdata,
    output logic [$clog2(DEPTH+1)-1:0]   o_rd_lnk,
    output logic [DATA_WIDTH-1:0]        o_rd_val
);
    localparam int SW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    logic [LW-1:0]         mem_lnk [DEPTH];
    logic [DATA_WIDTH-1:0] mem_val [DEPTH];
    logic [DEPTH-1:0]      r_vld;
    logic                  r_rvld;
    logic [SW-1:0]         r_raddr;
    logic [LW-1:0]         r_rlnk;
    logic [DATA_WIDTH-1:0] r_rval;

    // Memory arrays and read data register
    always_ff @(posedge i_clk) begin
        if (i_ctl.lnk_we) begin
            mem_lnk[i_lnk_waddr] <= i_lnk_wdata;
        end
        if (i_ctl.val_we) begin
            mem_val[i_val_waddr] <= i_val_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rlnk  <= mem_lnk[i_rd_addr];
            r_rval  <= mem_val[i_rd_addr];
            r_raddr <= i_rd_addr;
        end
    end

    // Written flags for the link memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_ctl.lnk_we) begin
                r_vld[i_lnk_waddr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rvld <= r_vld[i_rd_addr];
            end
        end
    end

    // Unwritten link entries hold the reset chain: slot i points at i+1
    assign o_rd_lnk = r_rvld ? r_rlnk : (LW'(r_raddr) + LW'(1));
    assign o_rd_val = r_rval;

endmodule

@@ rtl/array_linked_list_engine.sv @@
// ---------------------------------------------------------------------------
// array_linked_list_engine
// Singly linked list of values in a fixed node store with a free chain.
// ---------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command beat (command, key, value); o_res returns the
//   result beats, the final one of each command marked by last. Every
//   command gives one beat, except a dump of a non-empty list, which gives
//   one beat per node in list order.
//   One command is in flight at a time; i_cmd.ready is high while idle.
//   Insert front and delete front touch only the head of the list;
//   back/after/before commands walk the list one node per step.
//   A dump streams one beat per cycle while the receiver takes every beat.
//   The walk is bound by the single read port of the node store:
//   each step of a walk is one link read.
//   Results land in an output register, so a new command can be accepted
//   while the last result of the previous one still waits.
//   If the receiver stalls, the engine holds its walk (dump) or waits in
//   its start or final state until the output register frees up.
//   Reset (synchronous, active low) empties the list and puts every slot on
//   the free chain in order, with no sweep of the store.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module array_linked_list_engine #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alle_cmd_if.sink    i_cmd,
    alle_res_if.source  o_res
);
    localparam int SW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);
    localparam logic [LW-1:0] NIL = LW'(DEPTH);

    // Sign-extend a 32-bit field into the stored width
    function automatic logic [DATA_WIDTH-1:0] from_field(
        input logic [alle_pkg::FIELD_W-1:0] f
    );
        logic signed [63:0] w;
        w = 64'(signed'(f));
        return w[DATA_WIDTH-1:0];
    endfunction

    // Sign-extend a stored value and keep its low 32 bits
    function automatic logic [alle_pkg::FIELD_W-1:0] to_field(
        input logic [DATA_WIDTH-1:0] v
    );
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[alle_pkg::FIELD_W-1:0];
    endfunction

    alle_pkg::t_state r_state, n_state;

    logic [alle_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [DATA_WIDTH-1:0]      r_key, n_key;
    logic [DATA_WIDTH-1:0]      r_val, n_val;
    logic [LW-1:0]              r_head, n_head;
    logic [LW-1:0]              r_free, n_free;
    logic [LW-1:0]              r_cur, n_cur;
    logic [LW-1:0]              r_prev, n_prev;
    logic [LW-1:0]              r_pprev, n_pprev;
    logic [DATA_WIDTH-1:0]      r_pval, n_pval;
    logic [LW-1:0]              r_new, n_new;
    logic [LW-1:0]              r_wa, n_wa;
    logic [LW-1:0]              r_wd, n_wd;
    logic [alle_pkg::STAT_W-1:0] r_rstat, n_rstat;
    logic [DATA_WIDTH-1:0]      r_rval, n_rval;
    logic [LW-1:0]              r_rslot, n_rslot;

    logic                        r_ovld;
    logic [alle_pkg::STAT_W-1:0] r_ostat;
    logic [alle_pkg::FIELD_W-1:0] r_oval;
    logic [alle_pkg::SLOT_W-1:0] r_oslot;
    logic                        r_olast;

    // Store port signals
    alle_pkg::t_st_ctl     st_ctl;
    logic [LW-1:0]         rd_ptr;
    logic [LW-1:0]         lnk_wptr;
    logic [LW-1:0]         lnk_wdata;
    logic [LW-1:0]         val_wptr;
    logic [LW-1:0]         rd_lnk;
    logic [DATA_WIDTH-1:0] rd_val;

    // Result beat going into the output register
    logic                        emit;
    logic [alle_pkg::STAT_W-1:0] em_stat;
    logic [DATA_WIDTH-1:0]       em_val;
    logic [LW-1:0]               em_slot;
    logic                        em_last;

    logic accept;
    logic out_free;
    logic at_end;
    logic hit;
    logic is_ins;
    logic is_walk;

    alle_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (st_ctl),
        .i_rd_addr   (rd_ptr[SW-1:0]),
        .i_lnk_waddr (lnk_wptr[SW-1:0]),
        .i_lnk_wdata (lnk_wdata),
        .i_val_waddr (val_wptr[SW-1:0]),
        .i_val_wdata (r_val),
        .o_rd_lnk    (rd_lnk),
        .o_rd_val    (rd_val)
    );

    // Shared decode
    assign i_cmd.ready = (r_state == alle_pkg::S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_ovld || o_res.ready;
    assign at_end      = (rd_lnk == NIL);
    assign hit         = (rd_val == r_key);
    assign is_ins      = r_cmd inside {[alle_pkg::CMD_INS_FRONT:alle_pkg::CMD_INS_BEFORE]};
    assign is_walk     = r_cmd inside {[alle_pkg::CMD_DEL_FRONT:alle_pkg::CMD_DUMP]};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            alle_pkg::S_IDLE: begin
                if (accept) n_state = alle_pkg::S_START;
            end
            alle_pkg::S_START: begin
                if (is_ins && r_free != NIL) begin
                    n_state = alle_pkg::S_ALLOC;
                end else if (is_walk && r_head != NIL) begin
                    n_state = alle_pkg::S_WALK;
                end else if (out_free) begin
                    n_state = alle_pkg::S_IDLE;
                end
            end
            alle_pkg::S_ALLOC: begin
                if (r_cmd == alle_pkg::CMD_INS_FRONT || r_head == NIL) begin
                    n_state = alle_pkg::S_FIN;
                end else begin
                    n_state = alle_pkg::S_WALK;
                end
            end
            alle_pkg::S_WALK: begin
                case (r_cmd)
                    alle_pkg::CMD_INS_BACK, alle_pkg::CMD_INS_AFTER: begin
                        if ((r_cmd == alle_pkg::CMD_INS_AFTER && hit) || at_end)
                            n_state = alle_pkg::S_LINK2;
                    end
                    alle_pkg::CMD_INS_BEFORE: begin
                        if (hit) begin
                            n_state = (r_prev == NIL) ? alle_pkg::S_FIN : alle_pkg::S_LINK2;
                        end else if (at_end) begin
                            n_state = alle_pkg::S_LINK2;
                        end
                    end
                    alle_pkg::CMD_DEL_BACK: begin
                        if (at_end)
                            n_state = (r_prev == NIL) ? alle_pkg::S_FIN : alle_pkg::S_LINK2;
                    end
                    alle_pkg::CMD_DEL_AFTER: begin
                        if (at_end) begin
                            n_state = alle_pkg::S_FIN;
                        end else if (hit) begin
                            n_state = alle_pkg::S_GONE;
                        end
                    end
                    alle_pkg::CMD_DEL_BEFORE: begin
                        if (r_prev != NIL && hit) begin
                            n_state = (r_pprev == NIL) ? alle_pkg::S_FIN : alle_pkg::S_LINK2;
                        end else if (at_end) begin
                            n_state = alle_pkg::S_FIN;
                        end
                    end
                    alle_pkg::CMD_DUMP: begin
                        if (out_free && at_end) n_state = alle_pkg::S_IDLE;
                    end
                    default: n_state = alle_pkg::S_FIN;
                endcase
            end
            alle_pkg::S_GONE:  n_state = alle_pkg::S_LINK2;
            alle_pkg::S_LINK2: n_state = alle_pkg::S_FIN;
            alle_pkg::S_FIN: begin
                if (out_free) n_state = alle_pkg::S_IDLE;
            end
            default: n_state = alle_pkg::S_IDLE;
        endcase
    end

    // Datapath, store accesses and result beats
    always_comb begin
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_val   = r_val;
        n_head  = r_head;
        n_free  = r_free;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_pprev = r_pprev;
        n_pval  = r_pval;
        n_new   = r_new;
        n_wa    = r_wa;
        n_wd    = r_wd;
        n_rstat = r_rstat;
        n_rval  = r_rval;
        n_rslot = r_rslot;

        st_ctl    = '0;
        rd_ptr    = r_cur;
        lnk_wptr  = r_cur;
        lnk_wdata = r_free;
        val_wptr  = r_cur;

        emit    = 1'b0;
        em_stat = alle_pkg::STAT_NONE;
        em_val  = '0;
        em_slot = '0;
        em_last = 1'b1;

        case (r_state)
            alle_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd.command;
                    n_key = from_field(i_cmd.key);
                    n_val = from_field(i_cmd.value);
                end
            end

            // Check full store, empty list or unused code, else fetch first node
            alle_pkg::S_START: begin
                if (is_ins && r_free != NIL) begin
                    st_ctl.rd_en = 1'b1;
                    rd_ptr       = r_free;
                    n_cur        = r_free;
                end else if (is_walk && r_head != NIL) begin
                    st_ctl.rd_en = 1'b1;
                    rd_ptr       = r_head;
                    n_cur        = r_head;
                    n_prev       = NIL;
                    n_pprev      = NIL;
                end else if (out_free) begin
                    emit    = 1'b1;
                    em_stat = is_ins ? alle_pkg::STAT_FULL : alle_pkg::STAT_NONE;
                end
            end

            // Take the first free node and store the value
            alle_pkg::S_ALLOC: begin
                n_new         = r_cur;
                n_free        = rd_lnk;
                st_ctl.val_we = 1'b1;
                val_wptr      = r_cur;
                n_rstat       = alle_pkg::STAT_DONE;
                n_rval        = r_val;
                n_rslot       = r_cur;
                if (r_cmd == alle_pkg::CMD_INS_FRONT || r_head == NIL) begin
                    st_ctl.lnk_we = 1'b1;
                    lnk_wptr      = r_cur;
                    lnk_wdata     = r_head;
                    n_head        = r_cur;
                end else begin
                    st_ctl.rd_en = 1'b1;
                    rd_ptr       = r_head;
                    n_cur        = r_head;
                    n_prev       = NIL;
                    n_pprev      = NIL;
                end
            end

            // One node per cycle unless stalled; r_cur's link and value are read
            alle_pkg::S_WALK: begin
                case (r_cmd)
                    alle_pkg::CMD_INS_BACK, alle_pkg::CMD_INS_AFTER: begin
                        if ((r_cmd == alle_pkg::CMD_INS_AFTER && hit) || at_end) begin
                            st_ctl.lnk_we = 1'b1;
                            lnk_wptr      = r_new;
                            lnk_wdata     = rd_lnk;
                            n_wa          = r_cur;
                            n_wd          = r_new;
                        end else begin
                            st_ctl.rd_en = 1'b1;
                            rd_ptr       = rd_lnk;
                        end
                    end
                    alle_pkg::CMD_INS_BEFORE: begin
                        if (hit) begin
                            st_ctl.lnk_we = 1'b1;
                            lnk_wptr      = r_new;
                            lnk_wdata     = r_cur;
                            if (r_prev == NIL) begin
                                n_head = r_new;
                            end else begin
                                n_wa = r_prev;
                                n_wd = r_new;
                            end
                        end else if (at_end) begin
                            st_ctl.lnk_we = 1'b1;
                            lnk_wptr      = r_new;
                            lnk_wdata     = rd_lnk;
                            n_wa          = r_cur;
                            n_wd          = r_new;
                        end else begin
                            st_ctl.rd_en = 1'b1;
                            rd_ptr       = rd_lnk;
                        end
                    end
                    alle_pkg::CMD_DEL_FRONT: begin
                        n_head        = rd_lnk;
                        st_ctl.lnk_we = 1'b1;
                        lnk_wptr      = r_cur;
                        lnk_wdata     = r_free;
                        n_free        = r_cur;
                        n_rstat       = alle_pkg::STAT_DONE;
                        n_rval        = rd_val;
                        n_rslot       = r_cur;
                    end
                    alle_pkg::CMD_DEL_BACK: begin
                        if (at_end) begin
                            st_ctl.lnk_we = 1'b1;
                            lnk_wptr      = r_cur;
                            lnk_wdata     = r_free;
                            n_free        = r_cur;
                            n_rstat       = alle_pkg::STAT_DONE;
                            n_rval        = rd_val;
                            n_rslot       = r_cur;
                            if (r_prev == NIL) begin
                                n_head = NIL;
                            end else begin
                                n_wa = r_prev;
                                n_wd = NIL;
                            end
                        end else begin
                            st_ctl.rd_en = 1'b1;
                            rd_ptr       = rd_lnk;
                        end
                    end
                    alle_pkg::CMD_DEL_AFTER: begin
                        if (at_end) begin
                            n_rstat = alle_pkg::STAT_NONE;
                            n_rval  = '0;
                            n_rslot = '0;
                        end else begin
                            // on a hit the successor is fetched and removed
                            st_ctl.rd_en = 1'b1;
                            rd_ptr       = rd_lnk;
                        end
                    end
                    alle_pkg::CMD_DEL_BEFORE: begin
                        if (r_prev != NIL && hit) begin
                            st_ctl.lnk_we = 1'b1;
                            lnk_wptr      = r_prev;
                            lnk_wdata     = r_free;
                            n_free        = r_prev;
                            n_rstat       = alle_pkg::STAT_DONE;
                            n_rval        = r_pval;
                            n_rslot       = r_prev;
                            if (r_pprev == NIL) begin
                                n_head = r_cur;
                            end else begin
                                n_wa = r_pprev;
                                n_wd = r_cur;
                            end
                        end else if (at_end) begin
                            n_rstat = alle_pkg::STAT_NONE;
                            n_rval  = '0;
                            n_rslot = '0;
                        end else begin
                            st_ctl.rd_en = 1'b1;
                            rd_ptr       = rd_lnk;
                        end
                    end
                    alle_pkg::CMD_DUMP: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            em_stat = alle_pkg::STAT_DONE;
                            em_val  = rd_val;
                            em_slot = r_cur;
                            em_last = at_end;
                            if (!at_end) begin
                                st_ctl.rd_en = 1'b1;
                                rd_ptr       = rd_lnk;
                            end
                        end
                    end
                    default: begin
                        n_rstat = alle_pkg::STAT_NONE;
                        n_rval  = '0;
                        n_rslot = '0;
                    end
                endcase
                // step to the next node whenever a read was issued
                if (st_ctl.rd_en) begin
                    n_cur   = rd_lnk;
                    n_prev  = r_cur;
                    n_pprev = r_prev;
                    n_pval  = rd_val;
                end
            end

            // Removed node of delete-after: r_prev is the node that keeps the key
            alle_pkg::S_GONE: begin
                st_ctl.lnk_we = 1'b1;
                lnk_wptr      = r_prev;
                lnk_wdata     = rd_lnk;
                n_wa          = r_cur;
                n_wd          = r_free;
                n_free        = r_cur;
                n_rstat       = alle_pkg::STAT_DONE;
                n_rval        = rd_val;
                n_rslot       = r_cur;
            end

            // Second link write of a splice
            alle_pkg::S_LINK2: begin
                st_ctl.lnk_we = 1'b1;
                lnk_wptr      = r_wa;
                lnk_wdata     = r_wd;
            end

            alle_pkg::S_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_stat = r_rstat;
                    em_val  = r_rval;
                    em_slot = r_rslot;
                end
            end

            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alle_pkg::S_IDLE;
            r_head  <= NIL;
            r_free  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_val   <= n_val;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_pprev <= n_pprev;
        r_pval  <= n_pval;
        r_new   <= n_new;
        r_wa    <= n_wa;
        r_wd    <= n_wd;
        r_rstat <= n_rstat;
        r_rval  <= n_rval;
        r_rslot <= n_rslot;
        if (emit) begin
            r_ostat <= em_stat;
            r_oval  <= (em_stat == alle_pkg::STAT_DONE) ? to_field(em_val) : '0;
            r_oslot <= (em_stat == alle_pkg::STAT_DONE) ? alle_pkg::SLOT_W'(em_slot) : '0;
            r_olast <= em_last;
        end
    end

    // Result beat
    assign o_res.valid      = r_ovld;
    assign o_res.status     = r_ostat;
    assign o_res.item_value = r_oval;
    assign o_res.slot       = r_oslot;
    assign o_res.last       = r_olast;

    // Checks
    `ASSERT_NEXT(a_accept_starts, accept, r_state == alle_pkg::S_START,
        "accepted command did not start")
    `ASSERT_IMPLY(a_head_not_free, r_head != NIL, r_head != r_free,
        "head node also on free chain")
    `ASSERT_IMPLY(a_no_null_read, st_ctl.rd_en, rd_ptr != NIL,
        "node store read at null")
    `ASSERT_NEXT(a_last_to_idle, emit && em_last, r_state == alle_pkg::S_IDLE,
        "final beat did not end the command")

endmodule

@@ sim/array_linked_list_engine_tb.sv @@
// ---------------------------------------------------------------------------
// array_linked_list_engine_tb
// Self-checking bench for the array linked list engine. Commands go in on
// the command channel and a local copy of the node store, free chain and
// head tracks every accepted command to predict the result beats. Each
// result beat is compared field by field with the oldest predicted beat.
// A directed pass covers the empty list, every command, key hits and misses
// and the unused codes. Random traffic then runs under several idling
// mixes, including a pass that fills the store until it reports full.
// ---------------------------------------------------------------------------
module array_linked_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               NODES   = 32;
    localparam logic [5:0]       NIL     = 6'd32;
    localparam logic [alle_pkg::CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [alle_pkg::CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam logic signed [alle_pkg::FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [alle_pkg::FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [alle_pkg::STAT_W-1:0]         status;
        logic signed [alle_pkg::FIELD_W-1:0] item_value;
        logic [alle_pkg::SLOT_W-1:0]         slot;
        logic                                last;
    } t_res_beat;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    alle_cmd_if cmd_bus ();
    alle_res_if res_bus ();

    array_linked_list_engine dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // Local copy of the list state
    logic signed [alle_pkg::FIELD_W-1:0] node_val [NODES];
    logic [5:0]                          node_nxt [NODES];
    logic [5:0]                          list_head;
    logic [5:0]                          free_head;

    t_res_beat   beats_due [$];
    int unsigned mismatches   = 0;
    int unsigned snd_gap_pct  = 0;
    int unsigned rcv_stall_pct = 0;

    always #5ns clk = ~clk;

    // Receiver back-pressure
    initial res_bus.ready = 1'b0;
    always @(negedge clk) begin
        res_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void expect_beat(input logic [alle_pkg::STAT_W-1:0] status,
                                        input logic signed [alle_pkg::FIELD_W-1:0] value,
                                        input logic [5:0] slot, input logic last);
        t_res_beat b;
        b.status     = status;
        b.item_value = (status == alle_pkg::STAT_DONE) ? value : '0;
        b.slot       = (status == alle_pkg::STAT_DONE) ? slot[alle_pkg::SLOT_W-1:0] : '0;
        b.last       = last;
        beats_due.push_back(b);
    endfunction

    // Apply one accepted command to the local list and queue its beats
    task automatic apply_list_cmd(input logic [alle_pkg::CMD_W-1:0] cmd,
                                  input logic signed [alle_pkg::FIELD_W-1:0] key,
                                  input logic signed [alle_pkg::FIELD_W-1:0] val);
        logic [5:0] s;
        logic [5:0] i;
        logic [5:0] prev;
        logic [5:0] gone;
        gone = NIL;
        prev = NIL;
        case (cmd)
            alle_pkg::CMD_INS_FRONT, alle_pkg::CMD_INS_BACK,
            alle_pkg::CMD_INS_AFTER, alle_pkg::CMD_INS_BEFORE: begin
                if (free_head == NIL) begin
                    expect_beat(alle_pkg::STAT_FULL, '0, '0, 1'b1);
                end else begin
                    s = free_head;
                    free_head = node_nxt[s];
                    node_val[s] = val;
                    node_nxt[s] = NIL;
                    if (cmd == alle_pkg::CMD_INS_FRONT || list_head == NIL ||
                        (cmd == alle_pkg::CMD_INS_BEFORE && node_val[list_head] == key)) begin
                        node_nxt[s] = list_head;
                        list_head = s;
                    end else begin
                        // walk to the pivot, or the tail when the key is absent
                        i = list_head;
                        while (node_nxt[i] != NIL) begin
                            if (cmd == alle_pkg::CMD_INS_AFTER && node_val[i] == key) break;
                            if (cmd == alle_pkg::CMD_INS_BEFORE &&
                                node_val[node_nxt[i]] == key) break;
                            i = node_nxt[i];
                        end
                        node_nxt[s] = node_nxt[i];
                        node_nxt[i] = s;
                    end
                    expect_beat(alle_pkg::STAT_DONE, val, s, 1'b1);
                end
            end
            alle_pkg::CMD_DEL_FRONT, alle_pkg::CMD_DEL_BACK,
            alle_pkg::CMD_DEL_AFTER, alle_pkg::CMD_DEL_BEFORE: begin
                if (list_head != NIL) begin
                    i = list_head;
                    if (cmd == alle_pkg::CMD_DEL_FRONT) begin
                        gone = list_head;
                        list_head = node_nxt[gone];
                    end else if (cmd == alle_pkg::CMD_DEL_BACK) begin
                        while (node_nxt[i] != NIL) begin
                            prev = i;
                            i = node_nxt[i];
                        end
                        if (prev == NIL) list_head = NIL;
                        else             node_nxt[prev] = NIL;
                        gone = i;
                    end else if (cmd == alle_pkg::CMD_DEL_AFTER) begin
                        // first key node that has a successor
                        while (node_nxt[i] != NIL) begin
                            if (node_val[i] == key) begin
                                gone = node_nxt[i];
                                node_nxt[i] = node_nxt[gone];
                                break;
                            end
                            i = node_nxt[i];
                        end
                    end else begin
                        // key on the head alone never matches
                        while (node_nxt[i] != NIL) begin
                            if (node_val[node_nxt[i]] == key) begin
                                if (prev == NIL) list_head = node_nxt[i];
                                else             node_nxt[prev] = node_nxt[i];
                                gone = i;
                                break;
                            end
                            prev = i;
                            i = node_nxt[i];
                        end
                    end
                end
                if (gone == NIL) begin
                    expect_beat(alle_pkg::STAT_NONE, '0, '0, 1'b1);
                end else begin
                    expect_beat(alle_pkg::STAT_DONE, node_val[gone], gone, 1'b1);
                    node_nxt[gone] = free_head;
                    free_head = gone;
                end
            end
            alle_pkg::CMD_DUMP: begin
                if (list_head == NIL) begin
                    expect_beat(alle_pkg::STAT_NONE, '0, '0, 1'b1);
                end else begin
                    i = list_head;
                    while (i != NIL) begin
                        expect_beat(alle_pkg::STAT_DONE, node_val[i], i, node_nxt[i] == NIL);
                        i = node_nxt[i];
                    end
                end
            end
            default: expect_beat(alle_pkg::STAT_NONE, '0, '0, 1'b1);
        endcase
    endtask

    // Drive one command beat, wait for the handshake, then predict
    task automatic send_cmd(input logic [alle_pkg::CMD_W-1:0] cmd,
                            input logic signed [alle_pkg::FIELD_W-1:0] key,
                            input logic signed [alle_pkg::FIELD_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < snd_gap_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= cmd;
        cmd_bus.key     <= key;
        cmd_bus.value   <= val;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        apply_list_cmd(cmd, key, val);
    endtask

    // Values mix duplicates, extremes and full-range noise
    function automatic logic signed [alle_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(3))
            0:       return alle_pkg::FIELD_W'(int'($urandom_range(4)) - 2);
            1:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default: return $urandom;
        endcase
    endfunction

    // Keys mostly hit a node already in the list
    function automatic logic signed [alle_pkg::FIELD_W-1:0] pick_key();
        int         len;
        logic [5:0] i;
        len = 0;
        i = list_head;
        while (i != NIL) begin
            len++;
            i = node_nxt[i];
        end
        if (len != 0 && $urandom_range(99) < 70) begin
            i = list_head;
            repeat ($urandom_range(len - 1)) i = node_nxt[i];
            return node_val[i];
        end
        return pick_value();
    endfunction

    task automatic set_idling(input int unsigned snd_pct, input int unsigned rcv_pct);
        snd_gap_pct   = snd_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    // Empty list, every command, key hits and misses, unused codes
    task automatic test_directed_cases();
        send_cmd(alle_pkg::CMD_DUMP,       '0, '0);
        send_cmd(alle_pkg::CMD_DEL_FRONT,  '0, '0);
        send_cmd(alle_pkg::CMD_DEL_BACK,   '0, '0);
        send_cmd(alle_pkg::CMD_DEL_AFTER,  '0, '0);
        send_cmd(alle_pkg::CMD_DEL_BEFORE, '0, '0);
        // inserts into an empty list and before the head become the head
        send_cmd(alle_pkg::CMD_INS_AFTER,  32'sd5, VAL_MAX);
        send_cmd(alle_pkg::CMD_INS_BEFORE, VAL_MAX, VAL_MIN);
        send_cmd(alle_pkg::CMD_INS_BACK,   '0, '0);
        send_cmd(alle_pkg::CMD_INS_FRONT,  '0, -32'sd1);
        // missing pivot appends at the tail
        send_cmd(alle_pkg::CMD_INS_AFTER,  32'sd12345, 32'sh5555_5555);
        send_cmd(alle_pkg::CMD_INS_BEFORE, 32'sd12345, 32'shAAAA_AAAA);
        // duplicate keys: first node in list order wins
        send_cmd(alle_pkg::CMD_INS_AFTER,  '0, '0);
        send_cmd(alle_pkg::CMD_INS_BEFORE, '0, 32'sd7);
        send_cmd(alle_pkg::CMD_DUMP,       '0, '0);
        // delete before: key on head only, then key on second node
        send_cmd(alle_pkg::CMD_DEL_BEFORE, -32'sd1, '0);
        send_cmd(alle_pkg::CMD_DEL_BEFORE, VAL_MIN, '0);
        // delete after a key sitting on the tail
        send_cmd(alle_pkg::CMD_DEL_AFTER,  32'shAAAA_AAAA, '0);
        send_cmd(alle_pkg::CMD_DEL_AFTER,  '0, '0);
        send_cmd(alle_pkg::CMD_DEL_BEFORE, '0, '0);
        send_cmd(alle_pkg::CMD_DEL_BACK,   '0, '0);
        send_cmd(alle_pkg::CMD_DEL_FRONT,  '0, '0);
        send_cmd(CMD_UNUSED_LO,  VAL_MIN, VAL_MAX);
        send_cmd(CMD_UNUSED_HI,  -32'sd1, VAL_MIN);
        send_cmd(alle_pkg::CMD_DUMP,       '0, '0);
    endtask

    // Random command mix; ins_pct weights inserts over deletes
    task automatic test_random_traffic(input int n_items, input int ins_pct);
        int                         r;
        logic [alle_pkg::CMD_W-1:0] cmd;
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < 3)
                cmd = alle_pkg::CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            else if (r < 10)
                cmd = alle_pkg::CMD_DUMP;
            else if (r < 10 + ins_pct * 90 / 100)
                cmd = alle_pkg::CMD_INS_FRONT + alle_pkg::CMD_W'($urandom_range(3));
            else
                cmd = alle_pkg::CMD_DEL_FRONT + alle_pkg::CMD_W'($urandom_range(3));
            send_cmd(cmd, pick_key(), pick_value());
        end
    endtask

    // Fill every slot, overflow twice, then dump the full list
    task automatic test_store_full();
        while (free_head != NIL)
            send_cmd(alle_pkg::CMD_INS_FRONT + alle_pkg::CMD_W'($urandom_range(3)),
                     pick_key(), pick_value());
        repeat (2)
            send_cmd(alle_pkg::CMD_INS_FRONT + alle_pkg::CMD_W'($urandom_range(3)),
                     pick_key(), pick_value());
        send_cmd(alle_pkg::CMD_DUMP, '0, '0);
    endtask

    // Result checker
    always @(posedge clk) begin : check_results
        t_res_beat want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("beat with none due: status %0d value %0d slot %0d",
                                          res_bus.status, res_bus.item_value, res_bus.slot));
            end else begin
                want = beats_due.pop_front();
                if (res_bus.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              res_bus.status, want.status));
                if (res_bus.item_value !== want.item_value)
                    report_mismatch($sformatf("item_value got %0d want %0d",
                                              res_bus.item_value, want.item_value));
                if (res_bus.slot !== want.slot)
                    report_mismatch($sformatf("slot got %0d want %0d",
                                              res_bus.slot, want.slot));
                if (res_bus.last !== want.last)
                    report_mismatch($sformatf("last got %0d want %0d",
                                              res_bus.last, want.last));
            end
        end
    end

    // Main sequence
    initial begin
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = '0;
        cmd_bus.key     = '0;
        cmd_bus.value   = '0;
        for (int k = 0; k < NODES; k++) begin
            node_val[k] = '0;
            node_nxt[k] = 6'(k + 1);
        end
        list_head = NIL;
        free_head = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(0, 0);
        test_directed_cases();
        test_random_traffic(14, 55);
        set_idling(86, 0);
        test_random_traffic(14, 60);
        set_idling(0, 86);
        test_store_full();
        test_random_traffic(14, 30);
        set_idling(33, 33);
        test_random_traffic(14, 40);

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (NODES * 2) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/alle_pkg.sv
rtl/alle_if.sv
rtl/alle_store.sv
rtl/array_linked_list_engine.sv
sim/array_linked_list_engine_tb.sv
